/* rtl/assert_macros.svh */
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error(msg);

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

/* rtl/rtfifo_pkg.sv */
package rtfifo_pkg;

	// Operation codes
	typedef enum logic [2:0] {
		OP_TX_PUSH  = 3'd0,
		OP_TX_POP   = 3'd1,
		OP_TX_FLUSH = 3'd2,
		OP_RX_PUSH  = 3'd3,
		OP_RX_POP   = 3'd4,
		OP_RX_FLUSH = 3'd5
	} op_t;

	typedef enum logic {
		ST_IDLE,
		ST_READ
	} state_t;

	typedef struct packed {
		logic tx_full;
		logic tx_thr;
		logic tx_under;
		logic rx_thr;
		logic rx_ready;
		logic rx_over;
	} levels_t;

	// Controller to datapath
	typedef struct packed {
		logic accept;
		logic capture;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic need_read;
	} sts_t;

	localparam int THR_W = 7;
	localparam logic [3:0] THR_RESET = 4'd7;
	localparam logic [THR_W-1:0] TX_THR_BASE = 7'd61;
	localparam logic [THR_W-1:0] RX_THR_STEP = 7'd4;

	// Transmit threshold: 61 - 4*s
	function automatic logic [THR_W-1:0] tx_thr(input logic [3:0] s);
		return TX_THR_BASE - {1'b0, s, 2'b00};
	endfunction

	// Receive threshold: 4*(s+1)
	function automatic logic [THR_W-1:0] rx_thr(input logic [3:0] s);
		return {1'b0, s, 2'b00} + RX_THR_STEP;
	endfunction

endpackage

/* rtl/rtfifo_ram.sv */
module rtfifo_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/rtfifo_ctrl.sv */
module rtfifo_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  logic               out_stall,
	input  rtfifo_pkg::sts_t   sts,
	output rtfifo_pkg::cmd_t   cmd
);

	rtfifo_pkg::state_t state_q, state_d;
	logic out_valid_q;
	logic out_free;
	logic can_take;

	assign out_free = !out_valid_q || !out_stall;
	assign can_take = (state_q == rtfifo_pkg::ST_IDLE) && out_free;

	// Next state: go read the RAM for a pop that has data
	always_comb begin
		state_d = state_q;
		case (state_q)
			rtfifo_pkg::ST_IDLE: begin
				if (can_take && in_valid && sts.need_read) begin
					state_d = rtfifo_pkg::ST_READ;
				end
			end
			rtfifo_pkg::ST_READ: begin
				state_d = rtfifo_pkg::ST_IDLE;
			end
			default: begin
				state_d = rtfifo_pkg::ST_IDLE;
			end
		endcase
	end

	// Commands
	always_comb begin
		cmd.accept  = 1'b0;
		cmd.capture = 1'b0;
		case (state_q)
			rtfifo_pkg::ST_IDLE: begin
				cmd.accept = can_take && in_valid;
			end
			rtfifo_pkg::ST_READ: begin
				cmd.capture = 1'b1;
			end
			default: begin
				cmd.accept = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rtfifo_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Result valid: set on a finished item, drop on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.capture || (cmd.accept && !sts.need_read)) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign in_stall  = !can_take;
	assign out_valid = out_valid_q;

endmodule

/* rtl/rtfifo_dp.sv */
module rtfifo_dp #(
	parameter int TX_DEPTH = 64,
	parameter int RX_DEPTH = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  rtfifo_pkg::cmd_t                  cmd,
	output rtfifo_pkg::sts_t                  sts,
	input  logic                              cfg_write,
	input  logic [3:0]                        cfg_data,
	input  logic [2:0]                        op,
	input  logic [7:0]                        data_byte,
	output logic [7:0]                        read_data,
	output logic                              accepted,
	output logic                              clear_sync_pulse,
	output logic                              clear_crc_pulse,
	output rtfifo_pkg::levels_t               levels,
	output logic [$clog2(TX_DEPTH+1)-1:0]     tx_level,
	output logic [$clog2(RX_DEPTH+1)-1:0]     rx_level
);

	localparam int TX_AW = $clog2(TX_DEPTH);
	localparam int TX_CW = $clog2(TX_DEPTH + 1);
	localparam int RX_AW = $clog2(RX_DEPTH);
	localparam int RX_CW = $clog2(RX_DEPTH + 1);

	logic [TX_AW-1:0] tx_head_q, tx_head_d, tx_head_inc, tx_wpos;
	logic [TX_CW-1:0] tx_count_q, tx_count_d, tx_thr_c;
	logic [RX_AW-1:0] rx_head_q, rx_head_d, rx_head_inc, rx_wpos;
	logic [RX_CW-1:0] rx_count_q, rx_count_d, rx_thr_c;
	logic [TX_AW:0]   tx_sum;
	logic [RX_AW:0]   rx_sum;
	rtfifo_pkg::levels_t lvl_q, lvl_d;
	logic [3:0] thr_q;
	logic tx_empty, tx_full_now, rx_empty, rx_full_now;
	logic tx_we, rx_we, acc_d, csync_d, ccrc_d;
	logic is_tx_pop, is_rx_pop;
	logic [7:0] tx_rdata, rx_rdata;
	logic [7:0] read_data_q;
	logic accepted_q, csync_q, ccrc_q, rd_rx_q;

	assign tx_empty    = (tx_count_q == '0);
	assign tx_full_now = (tx_count_q == TX_CW'(TX_DEPTH));
	assign rx_empty    = (rx_count_q == '0);
	assign rx_full_now = (rx_count_q == RX_CW'(RX_DEPTH));
	assign tx_thr_c    = TX_CW'(rtfifo_pkg::tx_thr(thr_q));
	assign rx_thr_c    = RX_CW'(rtfifo_pkg::rx_thr(thr_q));

	// Ring write positions and head advance
	assign tx_sum  = {1'b0, tx_head_q} + {1'b0, tx_count_q[TX_AW-1:0]};
	assign tx_wpos = (tx_sum >= (TX_AW+1)'(TX_DEPTH)) ?
		TX_AW'(tx_sum - (TX_AW+1)'(TX_DEPTH)) : tx_sum[TX_AW-1:0];
	assign rx_sum  = {1'b0, rx_head_q} + {1'b0, rx_count_q[RX_AW-1:0]};
	assign rx_wpos = (rx_sum >= (RX_AW+1)'(RX_DEPTH)) ?
		RX_AW'(rx_sum - (RX_AW+1)'(RX_DEPTH)) : rx_sum[RX_AW-1:0];
	assign tx_head_inc = (tx_head_q == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_head_q + 1'b1;
	assign rx_head_inc = (rx_head_q == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_head_q + 1'b1;

	assign is_tx_pop     = (op == rtfifo_pkg::OP_TX_POP);
	assign is_rx_pop     = (op == rtfifo_pkg::OP_RX_POP);
	assign sts.need_read = (is_tx_pop && !tx_empty) || (is_rx_pop && !rx_empty);

	// Next state of the rings and level signals for the offered op
	always_comb begin
		tx_head_d  = tx_head_q;
		tx_count_d = tx_count_q;
		rx_head_d  = rx_head_q;
		rx_count_d = rx_count_q;
		lvl_d      = lvl_q;
		tx_we      = 1'b0;
		rx_we      = 1'b0;
		acc_d      = 1'b0;
		csync_d    = 1'b0;
		ccrc_d     = 1'b0;
		case (op)
			rtfifo_pkg::OP_TX_PUSH: begin
				if (!tx_full_now) begin
					tx_we      = 1'b1;
					tx_count_d = tx_count_q + 1'b1;
					acc_d      = 1'b1;
					if (tx_count_d == TX_CW'(TX_DEPTH)) begin
						lvl_d.tx_full = 1'b1;
					end
					if (tx_count_d >= tx_thr_c) begin
						lvl_d.tx_thr = 1'b1;
					end
				end
			end
			rtfifo_pkg::OP_TX_POP: begin
				if (tx_empty) begin
					lvl_d.tx_under = 1'b1;
				end else begin
					tx_count_d = tx_count_q - 1'b1;
					tx_head_d  = tx_head_inc;
					acc_d      = 1'b1;
				end
				if (tx_count_d < tx_thr_c) begin
					lvl_d.tx_thr  = 1'b0;
					lvl_d.tx_full = 1'b0;
				end
			end
			rtfifo_pkg::OP_TX_FLUSH: begin
				tx_count_d     = '0;
				tx_head_d      = '0;
				lvl_d.tx_under = 1'b0;
				lvl_d.tx_thr   = 1'b0;
				lvl_d.tx_full  = 1'b0;
				acc_d          = 1'b1;
			end
			rtfifo_pkg::OP_RX_PUSH: begin
				if (rx_full_now) begin
					lvl_d.rx_over = 1'b1;
					csync_d       = 1'b1;
				end else begin
					rx_we      = 1'b1;
					rx_count_d = rx_count_q + 1'b1;
					acc_d      = 1'b1;
					if (rx_count_d >= rx_thr_c) begin
						lvl_d.rx_thr   = 1'b1;
						lvl_d.rx_ready = 1'b1;
					end
				end
			end
			rtfifo_pkg::OP_RX_POP: begin
				if (!rx_empty) begin
					ccrc_d     = 1'b1;
					rx_count_d = rx_count_q - 1'b1;
					rx_head_d  = rx_head_inc;
					acc_d      = 1'b1;
					if (rx_count_d == '0) begin
						lvl_d.rx_ready = 1'b0;
					end
					if (rx_count_d < rx_thr_c) begin
						lvl_d.rx_thr = 1'b0;
					end
				end
			end
			rtfifo_pkg::OP_RX_FLUSH: begin
				rx_count_d     = '0;
				rx_head_d      = '0;
				lvl_d.rx_over  = 1'b0;
				lvl_d.rx_ready = 1'b0;
				lvl_d.rx_thr   = 1'b0;
				acc_d          = 1'b1;
			end
			default: begin
				acc_d = 1'b0;
			end
		endcase
	end

	// Byte stores
	rtfifo_ram #(.WIDTH(8), .DEPTH(TX_DEPTH)) u_tx_ram (
		.clk   (clk),
		.we    (cmd.accept && tx_we),
		.waddr (tx_wpos),
		.wdata (data_byte),
		.re    (cmd.accept && is_tx_pop && !tx_empty),
		.raddr (tx_head_q),
		.rdata (tx_rdata)
	);

	rtfifo_ram #(.WIDTH(8), .DEPTH(RX_DEPTH)) u_rx_ram (
		.clk   (clk),
		.we    (cmd.accept && rx_we),
		.waddr (rx_wpos),
		.wdata (data_byte),
		.re    (cmd.accept && is_rx_pop && !rx_empty),
		.raddr (rx_head_q),
		.rdata (rx_rdata)
	);

	// Ring state, levels and threshold code
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_head_q  <= '0;
			tx_count_q <= '0;
			rx_head_q  <= '0;
			rx_count_q <= '0;
			lvl_q      <= '0;
			thr_q      <= rtfifo_pkg::THR_RESET;
		end else begin
			if (cmd.accept) begin
				tx_head_q  <= tx_head_d;
				tx_count_q <= tx_count_d;
				rx_head_q  <= rx_head_d;
				rx_count_q <= rx_count_d;
				lvl_q      <= lvl_d;
			end
			if (cfg_write) begin
				thr_q <= cfg_data;
			end
		end
	end

	// Result fields; a popped byte is captured from the RAM read register in the READ state
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			read_data_q <= '0;
			accepted_q  <= acc_d;
			csync_q     <= csync_d;
			ccrc_q      <= ccrc_d;
			rd_rx_q     <= is_rx_pop;
		end else if (cmd.capture) begin
			read_data_q <= rd_rx_q ? rx_rdata : tx_rdata;
		end
	end

	assign read_data        = read_data_q;
	assign accepted         = accepted_q;
	assign clear_sync_pulse = csync_q;
	assign clear_crc_pulse  = ccrc_q;
	assign levels           = lvl_q;
	assign tx_level         = tx_count_q;
	assign rx_level         = rx_count_q;

endmodule

/* rtl/radio_tx_rx_fifo_with_thresholds.sv */
// Push, flush and empty pop: result valid in the cycle after the input transfer.
// Pop of a stored byte: the byte passes the registered read of the byte RAM, then the result register.
// Throughput: one item per cycle while out_stall is low; a pop with data holds in_stall high during its RAM read.
// Reset (arst_n low): both FIFOs empty, all level signals low, threshold code 7.
// Byte store contents are not cleared by reset.
`include "assert_macros.svh"

module radio_tx_rx_fifo_with_thresholds #(
	parameter int TX_DEPTH = 64,
	parameter int RX_DEPTH = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [3:0]                    cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [2:0]                    op,
	input  logic [7:0]                    data_byte,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [7:0]                    read_data,
	output logic                          accepted,
	output logic                          tx_full_signal,
	output logic                          tx_threshold_signal,
	output logic                          tx_underflow_signal,
	output logic                          rx_threshold_signal,
	output logic                          rx_ready_signal,
	output logic                          rx_overflow_signal,
	output logic                          clear_sync_pulse,
	output logic                          clear_crc_pulse,
	output logic [$clog2(TX_DEPTH+1)-1:0] tx_level,
	output logic [$clog2(RX_DEPTH+1)-1:0] rx_level
);

	rtfifo_pkg::cmd_t    cmd;
	rtfifo_pkg::sts_t    sts;
	rtfifo_pkg::levels_t levels;

	rtfifo_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	rtfifo_dp #(.TX_DEPTH(TX_DEPTH), .RX_DEPTH(RX_DEPTH)) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.cfg_write        (cfg_write),
		.cfg_data         (cfg_data),
		.op               (op),
		.data_byte        (data_byte),
		.read_data        (read_data),
		.accepted         (accepted),
		.clear_sync_pulse (clear_sync_pulse),
		.clear_crc_pulse  (clear_crc_pulse),
		.levels           (levels),
		.tx_level         (tx_level),
		.rx_level         (rx_level)
	);

	assign tx_full_signal      = levels.tx_full;
	assign tx_threshold_signal = levels.tx_thr;
	assign tx_underflow_signal = levels.tx_under;
	assign rx_threshold_signal = levels.rx_thr;
	assign rx_ready_signal     = levels.rx_ready;
	assign rx_overflow_signal  = levels.rx_over;

	// Checks
	`ASSERT_IMPLIES(a_tx_level_range, clk, arst_n, 1'b1, tx_level <= TX_DEPTH, "tx level past depth")
	`ASSERT_IMPLIES(a_rx_ready_nonempty, clk, arst_n, rx_ready_signal, rx_level != '0, "rx ready while empty")
	`ASSERT_NEXT(a_tx_pop_level, clk, arst_n, in_valid && !in_stall && op == rtfifo_pkg::OP_TX_POP && tx_level != '0, tx_level == $past(tx_level) - 1'b1, "tx pop did not drop level")
	`ASSERT_IMPLIES(a_crc_pulse_acc, clk, arst_n, out_valid && clear_crc_pulse, accepted, "crc pulse without accepted pop")

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
	import rtfifo_pkg::*;

	localparam int FIFO_DEPTH = 64;
	localparam int CYCLE_LIMIT = 400000;
	localparam int MAX_GAP = 14;
	localparam int SETTLE_CYCLES = 4;
	localparam int HOLD_OFF_CYCLES = 200;
	localparam logic [2:0] OP_SPARE_A = 3'd6;
	localparam logic [2:0] OP_SPARE_B = 3'd7;
	localparam logic [3:0] THR_LOWEST = 4'd0;
	localparam logic [3:0] THR_HIGHEST = 4'd15;

	typedef struct {
		logic [7:0] rd;
		logic       acc;
		levels_t    lv;
		logic       csync;
		logic       ccrc;
		logic [6:0] tx_cnt;
		logic [6:0] rx_cnt;
	} fifo_result_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_write;
	logic [3:0] cfg_data;
	logic       in_valid;
	logic       in_stall;
	logic [2:0] op;
	logic [7:0] data_byte;
	logic       out_valid;
	logic       out_stall;
	logic [7:0] read_data;
	logic       accepted;
	logic       tx_full_signal;
	logic       tx_threshold_signal;
	logic       tx_underflow_signal;
	logic       rx_threshold_signal;
	logic       rx_ready_signal;
	logic       rx_overflow_signal;
	logic       clear_sync_pulse;
	logic       clear_crc_pulse;
	logic [6:0] tx_level;
	logic [6:0] rx_level;

	// Shadow copy of both rings, their pointers, levels and threshold code
	logic [7:0]   tx_mem [FIFO_DEPTH];
	logic [7:0]   rx_mem [FIFO_DEPTH];
	int           tx_rd_ptr;
	int           tx_fill;
	int           rx_rd_ptr;
	int           rx_fill;
	levels_t      lv_state;
	logic [3:0]   thr_code;
	fifo_result_t pending_results [$];

	int fail_count = 0;
	int cycle_count = 0;
	bit tx_idle_on = 1'b1;
	bit rx_idle_on = 1'b1;
	int rx_hold_req = 0;

	radio_tx_rx_fifo_with_thresholds #(
		.TX_DEPTH(FIFO_DEPTH),
		.RX_DEPTH(FIFO_DEPTH)
	) i_dut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg_write           (cfg_write),
		.cfg_data            (cfg_data),
		.in_valid            (in_valid),
		.in_stall            (in_stall),
		.op                  (op),
		.data_byte           (data_byte),
		.out_valid           (out_valid),
		.out_stall           (out_stall),
		.read_data           (read_data),
		.accepted            (accepted),
		.tx_full_signal      (tx_full_signal),
		.tx_threshold_signal (tx_threshold_signal),
		.tx_underflow_signal (tx_underflow_signal),
		.rx_threshold_signal (rx_threshold_signal),
		.rx_ready_signal     (rx_ready_signal),
		.rx_overflow_signal  (rx_overflow_signal),
		.clear_sync_pulse    (clear_sync_pulse),
		.clear_crc_pulse     (clear_crc_pulse),
		.tx_level            (tx_level),
		.rx_level            (rx_level)
	);

	always #1 clk = ~clk;

	// Abort a run that hangs
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	// Apply one operation to the shadow FIFOs and queue the result it must give
	function automatic void fifo_predict(input logic [2:0] code, input logic [7:0] byte_in);
		fifo_result_t r;
		int tx_mark;
		int rx_mark;
		tx_mark = 61 - 4 * int'(thr_code);
		rx_mark = 4 * (int'(thr_code) + 1);
		r.rd = 8'h00;
		r.acc = 1'b0;
		r.csync = 1'b0;
		r.ccrc = 1'b0;
		case (code)
			OP_TX_PUSH: begin
				if (tx_fill < FIFO_DEPTH) begin
					tx_mem[(tx_rd_ptr + tx_fill) % FIFO_DEPTH] = byte_in;
					tx_fill++;
					if (tx_fill == FIFO_DEPTH)
						lv_state.tx_full = 1'b1;
					if (tx_fill >= tx_mark)
						lv_state.tx_thr = 1'b1;
					r.acc = 1'b1;
				end
			end
			OP_TX_POP: begin
				if (tx_fill == 0) begin
					lv_state.tx_under = 1'b1;
				end else begin
					r.rd = tx_mem[tx_rd_ptr];
					tx_rd_ptr = (tx_rd_ptr + 1) % FIFO_DEPTH;
					tx_fill--;
					r.acc = 1'b1;
				end
				// threshold check runs even on an underrun
				if (tx_fill < tx_mark) begin
					lv_state.tx_thr = 1'b0;
					lv_state.tx_full = 1'b0;
				end
			end
			OP_TX_FLUSH: begin
				tx_fill = 0;
				tx_rd_ptr = 0;
				lv_state.tx_under = 1'b0;
				lv_state.tx_thr = 1'b0;
				lv_state.tx_full = 1'b0;
				r.acc = 1'b1;
			end
			OP_RX_PUSH: begin
				if (rx_fill >= FIFO_DEPTH) begin
					lv_state.rx_over = 1'b1;
					r.csync = 1'b1;
				end else begin
					rx_mem[(rx_rd_ptr + rx_fill) % FIFO_DEPTH] = byte_in;
					rx_fill++;
					if (rx_fill >= rx_mark) begin
						lv_state.rx_thr = 1'b1;
						lv_state.rx_ready = 1'b1;
					end
					r.acc = 1'b1;
				end
			end
			OP_RX_POP: begin
				if (rx_fill != 0) begin
					r.ccrc = 1'b1;
					r.rd = rx_mem[rx_rd_ptr];
					rx_rd_ptr = (rx_rd_ptr + 1) % FIFO_DEPTH;
					rx_fill--;
					if (rx_fill == 0)
						lv_state.rx_ready = 1'b0;
					if (rx_fill < rx_mark)
						lv_state.rx_thr = 1'b0;
					r.acc = 1'b1;
				end
			end
			OP_RX_FLUSH: begin
				rx_fill = 0;
				rx_rd_ptr = 0;
				lv_state.rx_over = 1'b0;
				lv_state.rx_ready = 1'b0;
				lv_state.rx_thr = 1'b0;
				r.acc = 1'b1;
			end
			default: begin
			end
		endcase
		r.lv = lv_state;
		r.tx_cnt = 7'(tx_fill);
		r.rx_cnt = 7'(rx_fill);
		pending_results.push_back(r);
	endfunction

	task automatic check_field(input string name, input logic [7:0] want_v,
			input logic [7:0] got_v);
		if (got_v !== want_v) begin
			$display("%0t: %s expected %0h actual %0h", $time, name, want_v, got_v);
			fail_count++;
		end
	endtask

	// Compare every result transfer with the oldest prediction
	always @(posedge clk) begin : result_check
		fifo_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result transfer expected none actual read_data %0h",
					$time, read_data);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("read_data", want.rd, read_data);
				check_field("accepted", 8'(want.acc), 8'(accepted));
				check_field("tx_full_signal", 8'(want.lv.tx_full), 8'(tx_full_signal));
				check_field("tx_threshold_signal", 8'(want.lv.tx_thr),
					8'(tx_threshold_signal));
				check_field("tx_underflow_signal", 8'(want.lv.tx_under),
					8'(tx_underflow_signal));
				check_field("rx_threshold_signal", 8'(want.lv.rx_thr),
					8'(rx_threshold_signal));
				check_field("rx_ready_signal", 8'(want.lv.rx_ready), 8'(rx_ready_signal));
				check_field("rx_overflow_signal", 8'(want.lv.rx_over),
					8'(rx_overflow_signal));
				check_field("clear_sync_pulse", 8'(want.csync), 8'(clear_sync_pulse));
				check_field("clear_crc_pulse", 8'(want.ccrc), 8'(clear_crc_pulse));
				check_field("tx_level", 8'(want.tx_cnt), 8'(tx_level));
				check_field("rx_level", 8'(want.rx_cnt), 8'(rx_level));
			end
		end
	end

	// Drive out_stall: a random gap per result while rx_idle_on is set, or a long hold-off on request
	initial begin : result_sink
		int stall_len;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			stall_len = rx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
			if (rx_hold_req != 0) begin
				stall_len = rx_hold_req;
				rx_hold_req = 0;
			end
			if (stall_len != 0) begin
				@(negedge clk);
				out_stall <= 1'b1;
				repeat (stall_len - 1) @(negedge clk);
			end
			@(negedge clk);
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	// Offer one item, after a random gap while tx_idle_on is set, and hold it until the transfer
	task automatic send_item(input logic [2:0] code, input logic [7:0] byte_in);
		int gap;
		gap = tx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
		if (gap != 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		op <= code;
		data_byte <= byte_in;
		do @(posedge clk); while (in_stall);
		fifo_predict(code, byte_in);
	endtask

	// Stop offering and wait until every predicted result has come
	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_threshold(input logic [3:0] code);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_data <= code;
		@(negedge clk);
		cfg_write <= 1'b0;
		thr_code = code;
	endtask

	function automatic logic [2:0] pick_op(input int push_pct);
		int r;
		bit on_tx;
		r = $urandom_range(0, 99);
		on_tx = 1'($urandom_range(0, 1));
		if (r < 2)
			return ($urandom_range(0, 1) != 0) ? OP_SPARE_A : OP_SPARE_B;
		if (r < 4)
			return on_tx ? OP_TX_FLUSH : OP_RX_FLUSH;
		if ($urandom_range(0, 99) < push_pct)
			return on_tx ? OP_TX_PUSH : OP_RX_PUSH;
		return on_tx ? OP_TX_POP : OP_RX_POP;
	endfunction

	// Empty pops, spare codes, byte extremes and flushes at the reset threshold
	task automatic test_directed();
		send_item(OP_TX_POP, 8'($urandom_range(0, 255)));
		send_item(OP_RX_POP, 8'($urandom_range(0, 255)));
		send_item(OP_SPARE_A, 8'hFF);
		send_item(OP_SPARE_B, 8'h00);
		send_item(OP_TX_PUSH, 8'h00);
		send_item(OP_TX_PUSH, 8'hFF);
		send_item(OP_TX_POP, 8'h00);
		send_item(OP_TX_POP, 8'hFF);
		send_item(OP_TX_POP, 8'h00);
		send_item(OP_RX_PUSH, 8'hFF);
		send_item(OP_RX_PUSH, 8'h00);
		send_item(OP_RX_POP, 8'hFF);
		send_item(OP_RX_POP, 8'h00);
		send_item(OP_RX_PUSH, 8'hA5);
		send_item(OP_TX_PUSH, 8'h5A);
		send_item(OP_TX_FLUSH, 8'h00);
		send_item(OP_RX_FLUSH, 8'hFF);
		send_item(OP_TX_POP, 8'h00);
		send_item(OP_TX_FLUSH, 8'h00);
		drain_results();
	endtask

	// Fill each FIFO past full, drain it past empty, then flush
	task automatic test_fill_limits(input logic [3:0] code);
		drain_results();
		write_threshold(code);
		repeat (FIFO_DEPTH + 1) send_item(OP_TX_PUSH, 8'($urandom_range(0, 255)));
		repeat (FIFO_DEPTH + 2) send_item(OP_TX_POP, 8'($urandom_range(0, 255)));
		send_item(OP_TX_FLUSH, 8'($urandom_range(0, 255)));
		repeat (FIFO_DEPTH + 2) send_item(OP_RX_PUSH, 8'($urandom_range(0, 255)));
		repeat (FIFO_DEPTH + 2) send_item(OP_RX_POP, 8'($urandom_range(0, 255)));
		send_item(OP_RX_FLUSH, 8'($urandom_range(0, 255)));
		drain_results();
	endtask

	// Random traffic in phases, each with its own threshold and idle mode
	task automatic test_random_traffic(input int phases, input int per_phase);
		int bias;
		int mode;
		for (int p = 0; p < phases; p++) begin
			drain_results();
			write_threshold(4'($urandom_range(0, 15)));
			mode = (p == 0) ? 0 : $urandom_range(0, 3);
			tx_idle_on = mode[0];
			rx_idle_on = mode[1];
			bias = 50;
			for (int i = 0; i < per_phase; i++) begin
				// swing the push rate so levels sweep between empty and full
				if (i % 48 == 0)
					bias = 10 + 20 * $urandom_range(0, 4);
				send_item(pick_op(bias), 8'($urandom_range(0, 255)));
			end
		end
		drain_results();
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
	endtask

	// Hold off the receiver while items keep coming, then resume random gaps on both sides
	task automatic test_backpressure();
		drain_results();
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		rx_hold_req = HOLD_OFF_CYCLES;
		repeat (90) send_item(pick_op(60), 8'($urandom_range(0, 255)));
		drain_results();
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		repeat (30) send_item(pick_op(50), 8'($urandom_range(0, 255)));
		drain_results();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_data = THR_RESET;
		in_valid = 1'b0;
		op = OP_TX_PUSH;
		data_byte = 8'h00;
		tx_rd_ptr = 0;
		tx_fill = 0;
		rx_rd_ptr = 0;
		rx_fill = 0;
		lv_state = '0;
		thr_code = THR_RESET;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_fill_limits(THR_LOWEST);
		test_fill_limits(THR_HIGHEST);
		test_random_traffic(4, 300);
		test_backpressure();

		drain_results();
		if (fail_count == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule
